FILE: src/rate_limited_capture_ring_top_assert.svh
// assertion macros used by the capture ring datapath
`ifndef RATE_LIMITED_CAPTURE_RING_TOP_ASSERT_SVH
`define RATE_LIMITED_CAPTURE_RING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define RLCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while in reset
`define RLCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rlcr_pkg.sv
`timescale 1ns / 1ps

package rlcr_pkg;

    localparam int unsigned MIN_DEPTH = 10;
    localparam int unsigned DIU_BITS  = 7;
    localparam int unsigned DIU_MAX   = (1 << DIU_BITS) - 1;
    localparam int unsigned DIU_RST   = 64;

    localparam logic [63:0] MIN_PERIOD_RST = 64'd333333333;

    // request codes
    localparam logic [1:0] REQ_ARRIVAL = 2'd0;
    localparam logic [1:0] REQ_COLLECT = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    // register indexes
    localparam int unsigned REG_MIN_PERIOD = 0;
    localparam int unsigned REG_DEPTH      = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM_ARR,
        ST_NORM_COL,
        ST_ARRIVE,
        ST_SCAN,
        ST_FLUSH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic norm;
        logic arrive;
        logic scan_start;
        logic scan;
        logic emit_flush;
        logic emit_resp;
    } cmd_t;

    typedef struct packed {
        logic base_ok;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

FILE: src/rlcr_ctrl.sv
`timescale 1ns / 1ps

module rlcr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      req_type,
    input  rlcr_pkg::stat_t stat,
    output logic            in_ready,
    output rlcr_pkg::cmd_t  cmd
);
    import rlcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_ARRIVAL: state_next = ST_NORM_ARR;
                        REQ_COLLECT: state_next = ST_NORM_COL;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_NORM_ARR:
            begin
                if (stat.base_ok)
                begin
                    state_next = ST_ARRIVE;
                end
            end
            ST_NORM_COL:
            begin
                if (stat.base_ok)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_ARRIVE: state_next = ST_RESP;
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH, ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.clear  = in_valid && (req_type == REQ_CLEAR);
            end
            ST_NORM_ARR:
            begin
                cmd.norm = !stat.base_ok;
            end
            ST_NORM_COL:
            begin
                cmd.norm       = !stat.base_ok;
                cmd.scan_start = stat.base_ok;
            end
            ST_ARRIVE:
            begin
                cmd.arrive = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = !stat.scan_done;
            end
            ST_FLUSH:
            begin
                cmd.emit_flush = stat.out_free;
            end
            ST_RESP:
            begin
                cmd.emit_resp = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/rlcr_datapath.sv
`timescale 1ns / 1ps
`include "rate_limited_capture_ring_top_assert.svh"

module rlcr_datapath #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned TIME_BITS   = 48,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlcr_pkg::cmd_t                cmd,
    output rlcr_pkg::stat_t               stat,
    input  logic [TIME_BITS-1:0]          min_period,
    input  logic [rlcr_pkg::DIU_BITS-1:0] depth_in_use,
    input  logic [TIME_BITS-1:0]          arrival_time,
    input  logic [TIME_BITS-1:0]          frame_stamp,
    input  logic [HANDLE_BITS-1:0]        frame_handle,
    input  logic [TIME_BITS-1:0]          window_start,
    input  logic [TIME_BITS-1:0]          window_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [HANDLE_BITS-1:0]        out_handle,
    output logic [TIME_BITS-1:0]          out_stamp,
    output logic                          found,
    output logic                          accepted,
    output logic                          last
);
    import rlcr_pkg::*;

    // the depth register cannot name a slot beyond DIU_MAX
    localparam int unsigned SLOTS      = (DEPTH < DIU_MAX) ? DEPTH : DIU_MAX;
    localparam int unsigned SW         = $clog2(SLOTS);
    localparam int unsigned DW         = $clog2(SLOTS + 1);
    localparam int unsigned RST_NEWEST = ((DIU_RST < SLOTS) ? DIU_RST : SLOTS) - 1;

    // captured request
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   fstamp_reg;
    logic [HANDLE_BITS-1:0] fhandle_reg;
    logic [TIME_BITS-1:0]   wstart_reg;
    logic [TIME_BITS-1:0]   wend_reg;

    // ring store
    logic [SLOTS-1:0]       slot_valid_reg;
    logic [TIME_BITS-1:0]   stamp_mem [SLOTS];
    logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
    logic [SW-1:0]          newest_reg;
    logic [TIME_BITS-1:0]   last_time_reg;

    logic [DW-1:0]          eff_depth;
    logic [DW-1:0]          base_reg;
    logic                   acc_reg;
    logic [SW-1:0]          wr_idx;
    logic [TIME_BITS:0]     gap;
    logic                   arr_ok;

    // scan
    logic [SW-1:0]          sidx_reg;
    logic [SW-1:0]          sidx_next;
    logic [DW-1:0]          left_reg;
    logic [DW-1:0]          left_next;
    logic                   b_live_reg;
    logic                   b_live_next;
    logic                   rd_valid_reg;
    logic [TIME_BITS-1:0]   rd_stamp_reg;
    logic [HANDLE_BITS-1:0] rd_handle_reg;
    logic                   pend_live_reg;
    logic [TIME_BITS-1:0]   pend_stamp_reg;
    logic [HANDLE_BITS-1:0] pend_handle_reg;
    logic [DW-1:0]          sidx_inc;
    logic                   cls_skip;
    logic                   cls_stop;
    logic                   hit;
    logic                   stop;
    logic                   stall;
    logic                   issue;
    logic                   push;

    // output register
    logic                   out_valid_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [TIME_BITS-1:0]   out_stamp_reg;
    logic                   out_found_reg;
    logic                   out_acc_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic                   out_load;

    always_comb
    begin
        if (depth_in_use < DIU_BITS'(MIN_DEPTH))
        begin
            eff_depth = DW'(MIN_DEPTH);
        end
        else if (depth_in_use > DIU_BITS'(SLOTS))
        begin
            eff_depth = DW'(SLOTS);
        end
        else
        begin
            eff_depth = DW'(depth_in_use);
        end
    end

    assign wr_idx = base_reg[SW-1:0];
    assign gap    = {1'b0, now_reg} - {1'b0, last_time_reg};
    // a borrow means time went backwards: too soon
    assign arr_ok = !gap[TIME_BITS] && (gap[TIME_BITS-1:0] >= min_period);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg     <= arrival_time;
            fstamp_reg  <= frame_stamp;
            fhandle_reg <= frame_handle;
            wstart_reg  <= window_start;
            wend_reg    <= window_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            newest_reg     <= SW'(RST_NEWEST);
            last_time_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            slot_valid_reg <= '0;
            newest_reg     <= SW'(eff_depth - DW'(1));
            last_time_reg  <= '0;
        end
        else if (cmd.arrive && arr_ok)
        begin
            slot_valid_reg[wr_idx] <= 1'b1;
            newest_reg             <= wr_idx;
            last_time_reg          <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arrive && arr_ok)
        begin
            stamp_mem[wr_idx]  <= fstamp_reg;
            handle_mem[wr_idx] <= fhandle_reg;
        end
        if (issue)
        begin
            rd_stamp_reg  <= stamp_mem[sidx_reg];
            rd_handle_reg <= handle_mem[sidx_reg];
        end
    end

    // oldest slot = (newest + 1) mod depth, by repeated subtraction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            acc_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                base_reg <= DW'(newest_reg) + DW'(1);
                acc_reg  <= 1'b0;
            end
            else if (cmd.norm)
            begin
                base_reg <= base_reg - eff_depth;
            end
            else if (cmd.arrive)
            begin
                acc_reg <= arr_ok;
            end
        end
    end

    assign cls_skip = !rd_valid_reg || (rd_stamp_reg < wstart_reg);
    assign cls_stop = !cls_skip && (wend_reg < rd_stamp_reg);
    assign hit      = b_live_reg && !cls_skip && !cls_stop;
    assign stop     = b_live_reg && cls_stop;
    assign stall    = hit && pend_live_reg && !out_free;
    assign issue    = cmd.scan && !stall && !stop && (left_reg != '0);
    assign push     = cmd.scan && hit && pend_live_reg && out_free;
    assign sidx_inc = DW'(sidx_reg) + DW'(1);

    always_comb
    begin
        sidx_next   = sidx_reg;
        left_next   = left_reg;
        b_live_next = b_live_reg;
        if (cmd.scan_start)
        begin
            sidx_next   = base_reg[SW-1:0];
            left_next   = eff_depth;
            b_live_next = 1'b0;
        end
        else if (cmd.scan && stop)
        begin
            left_next   = '0;
            b_live_next = 1'b0;
        end
        else if (cmd.scan && !stall)
        begin
            b_live_next = issue;
            if (issue)
            begin
                left_next = left_reg - DW'(1);
                sidx_next = (sidx_inc == eff_depth) ? '0 : sidx_inc[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg      <= '0;
            left_reg      <= '0;
            b_live_reg    <= 1'b0;
            rd_valid_reg  <= 1'b0;
            pend_live_reg <= 1'b0;
        end
        else
        begin
            sidx_reg   <= sidx_next;
            left_reg   <= left_next;
            b_live_reg <= b_live_next;
            if (issue)
            begin
                rd_valid_reg <= slot_valid_reg[sidx_reg];
            end
            if (cmd.scan_start || cmd.emit_flush)
            begin
                pend_live_reg <= 1'b0;
            end
            else if (cmd.scan && hit && !stall)
            begin
                pend_live_reg <= 1'b1;
            end
        end
    end

    // one match held back until the next one or the end shows whether it is final
    always_ff @(posedge clk)
    begin
        if (cmd.scan && hit && !stall)
        begin
            pend_stamp_reg  <= rd_stamp_reg;
            pend_handle_reg <= rd_handle_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = push || cmd.emit_flush || cmd.emit_resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_handle_reg <= pend_handle_reg;
            out_stamp_reg  <= pend_stamp_reg;
            out_found_reg  <= 1'b1;
            out_acc_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_flush)
        begin
            out_handle_reg <= pend_live_reg ? pend_handle_reg : '0;
            out_stamp_reg  <= pend_live_reg ? pend_stamp_reg : '0;
            out_found_reg  <= pend_live_reg;
            out_acc_reg    <= 1'b0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_resp)
        begin
            out_handle_reg <= '0;
            out_stamp_reg  <= '0;
            out_found_reg  <= 1'b0;
            out_acc_reg    <= acc_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign stat.base_ok   = base_reg < eff_depth;
    assign stat.scan_done = !b_live_reg && (left_reg == '0);
    assign stat.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign out_handle = out_handle_reg;
    assign out_stamp  = out_stamp_reg;
    assign found      = out_found_reg;
    assign accepted   = out_acc_reg;
    assign last       = out_last_reg;

    `RLCR_ASSERT_NEXT(a_arrival_marks_slot, cmd.arrive && arr_ok, slot_valid_reg[newest_reg], "stored arrival left its slot empty")
    `RLCR_ASSERT_NOW(a_load_only_when_free, out_load, out_free, "result beat overwrote an untaken result")
    `RLCR_ASSERT_NEXT(a_clear_empties, cmd.clear, slot_valid_reg == '0, "clear left a slot marked valid")

endmodule

FILE: src/rate_limited_capture_ring_top.sv
// Rate-limited capture ring: keeps up to depth_in_use (clamped to at least 10
// and at most the slot count) stamped frame handles in a ring, overwriting the
// oldest, and stores an arrival only if min_period ticks have passed since the
// last stored one (time going backwards counts as too soon). One request beat
// is taken at a time, and in_ready is high only while the block waits for a
// request. An arrival passes through a pointer normalise state and an arrival
// state before its result is loaded, a clear or unknown request goes straight
// to its result; a collect walks the ring one slot per cycle while the output
// is not stalled, through a registered memory read, and stops early on a
// stamp past the window end. After depth_in_use is changed without a clear,
// the first arrival or collect reduces the ring pointer modulo the new depth
// by repeated subtraction. Every result beat sits in an output register, and
// a stalled output holds the scan in place. Slot contents need no clearing
// pass: per-slot valid bits are cleared at reset and by a clear request.
// Configuration over the APB port must only be written while no request is in
// flight; min_period sits at offset 0 and depth_in_use at offset 8.
`timescale 1ns / 1ps

module rate_limited_capture_ring_top #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned TIME_BITS   = 48,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [((TIME_BITS > 32) ? 4 : 3)-1:0]     paddr,
    input  logic [((TIME_BITS > 32) ? 64 : 32)-1:0]   pwdata,
    output logic [((TIME_BITS > 32) ? 64 : 32)-1:0]   prdata,
    output logic                                      pready,
    // request channel
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [1:0]                                req_type,
    input  logic [TIME_BITS-1:0]                      arrival_time,
    input  logic [TIME_BITS-1:0]                      frame_stamp,
    input  logic [HANDLE_BITS-1:0]                    frame_handle,
    input  logic [TIME_BITS-1:0]                      window_start,
    input  logic [TIME_BITS-1:0]                      window_end,
    // result channel
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [HANDLE_BITS-1:0]                    out_handle,
    output logic [TIME_BITS-1:0]                      out_stamp,
    output logic                                      found,
    output logic                                      accepted,
    output logic                                      last
);
    import rlcr_pkg::*;

    // registers wider than 32 bits move the port to a 64-bit bus, 8-byte stride
    localparam int unsigned CFG_DW = (TIME_BITS > 32) ? 64 : 32;
    localparam int unsigned ADDR_W = (TIME_BITS > 32) ? 4 : 3;

    logic [TIME_BITS-1:0] min_period_reg;
    logic [DIU_BITS-1:0]  depth_in_use_reg;
    logic                 cfg_wr;
    logic                 reg_idx;
    cmd_t                 cmd;
    stat_t                stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // the top address bit picks the register, lower bits are byte lanes
    assign reg_idx = paddr[ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg   <= TIME_BITS'(MIN_PERIOD_RST);
            depth_in_use_reg <= DIU_BITS'(DIU_RST);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                1'(REG_MIN_PERIOD): min_period_reg   <= pwdata[TIME_BITS-1:0];
                1'(REG_DEPTH):      depth_in_use_reg <= pwdata[DIU_BITS-1:0];
                default:            min_period_reg   <= min_period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            1'(REG_MIN_PERIOD): prdata = CFG_DW'(min_period_reg);
            1'(REG_DEPTH):      prdata = CFG_DW'(depth_in_use_reg);
            default:            prdata = '0;
        endcase
    end

    // sequencer: one request at a time, steps the datapath through its phases
    rlcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // ring memory, rate check, scan pipeline and output register
    rlcr_datapath #(
        .DEPTH       (DEPTH),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .min_period   (min_period_reg),
        .depth_in_use (depth_in_use_reg),
        .arrival_time (arrival_time),
        .frame_stamp  (frame_stamp),
        .frame_handle (frame_handle),
        .window_start (window_start),
        .window_end   (window_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_handle   (out_handle),
        .out_stamp    (out_stamp),
        .found        (found),
        .accepted     (accepted),
        .last         (last)
    );

endmodule

FILE: bench/rate_limited_capture_ring_top_tb.sv
`timescale 1ns / 1ps

module rate_limited_capture_ring_top_tb;
    import rlcr_pkg::*;

    localparam int unsigned TB_DEPTH       = 64;
    localparam int unsigned TB_TIME_BITS   = 48;
    localparam int unsigned TB_HANDLE_BITS = 32;
    localparam logic [47:0] TIME_MAX       = '1;
    localparam logic [31:0] HANDLE_MAX     = '1;
    // request code with no meaning to the block, answered with a bare last beat
    localparam logic [1:0]  REQ_UNUSED     = 2'd3;
    // quiet cycles tolerated on both channels and the register port
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // cycles allowed for the block to settle before a register write
    localparam int unsigned SETTLE_CYCLES  = 20;

    // one result beat as the block should present it
    typedef struct packed {
        logic [31:0] handle;
        logic [47:0] stamp;
        logic        found;
        logic        accepted;
        logic        last;
    } ring_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [47:0] arrival_time;
    logic [47:0] frame_stamp;
    logic [31:0] frame_handle;
    logic [47:0] window_start;
    logic [47:0] window_end;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_handle;
    logic [47:0] out_stamp;
    logic        found;
    logic        accepted;
    logic        last;

    // idling odds, in percent
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned err_count;
    int unsigned quiet_cycles;

    // result beats still owed by the block, oldest first
    ring_beat_t  due_beats[$];

    // shadow of the ring: slot contents, pointer, rate limiter and registers
    logic        ring_full[TB_DEPTH];
    logic [47:0] ring_stamp[TB_DEPTH];
    logic [31:0] ring_handle[TB_DEPTH];
    int unsigned ring_head;
    logic [47:0] last_take_time;
    logic [47:0] gap_ticks;
    logic [6:0]  depth_setting;

    // running stamp for well-formed frame sequences
    logic [47:0] stamp_cursor;

    rate_limited_capture_ring_top #(
        .DEPTH       (TB_DEPTH),
        .TIME_BITS   (TB_TIME_BITS),
        .HANDLE_BITS (TB_HANDLE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .arrival_time (arrival_time),
        .frame_stamp  (frame_stamp),
        .frame_handle (frame_handle),
        .window_start (window_start),
        .window_end   (window_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_handle   (out_handle),
        .out_stamp    (out_stamp),
        .found        (found),
        .accepted     (accepted),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // shadow ring
    // ---------------------------------------------------------------------

    // slots actually in use, with the register clamped to the legal span
    function automatic int unsigned ring_span();
        if (depth_setting < MIN_DEPTH)
            return MIN_DEPTH;
        if (depth_setting > TB_DEPTH)
            return TB_DEPTH;
        return depth_setting;
    endfunction

    function automatic ring_beat_t make_beat(input logic [31:0] h, input logic [47:0] s,
                                             input logic f, input logic a, input logic l);
        ring_beat_t b;
        b.handle   = h;
        b.stamp    = s;
        b.found    = f;
        b.accepted = a;
        b.last     = l;
        return b;
    endfunction

    // appends one beat to the owed list
    task automatic owe_beat(input ring_beat_t b);
        due_beats.insert(due_beats.size(), b);
    endtask

    // empties the ring and rewinds the rate limiter
    task automatic empty_ring_shadow();
        int unsigned k;
        for (k = 0; k < TB_DEPTH; k++)
        begin
            ring_full[k]   = 1'b0;
            ring_stamp[k]  = '0;
            ring_handle[k] = '0;
        end
        ring_head      = ring_span() - 1;
        last_take_time = '0;
    endtask

    // works out the beats one accepted request causes and queues them
    task automatic predict_ring_beats(input logic [1:0] req, input logic [47:0] now,
                                      input logic [47:0] fstamp, input logic [31:0] fhandle,
                                      input logic [47:0] ws, input logic [47:0] we);
        int unsigned span;
        int unsigned idx;
        int unsigned s;
        int unsigned i;
        logic        ok;
        logic        stop;
        logic        have_hit;
        ring_beat_t  hit;
        span     = ring_span();
        stop     = 1'b0;
        have_hit = 1'b0;
        hit      = '0;
        case (req)
            REQ_ARRIVAL:
            begin
                // time running backwards counts as too soon
                ok = (now >= last_take_time) && ((now - last_take_time) >= gap_ticks);
                if (ok)
                begin
                    last_take_time         = now;
                    ring_head              = (ring_head + 1) % span;
                    ring_full[ring_head]   = 1'b1;
                    ring_stamp[ring_head]  = fstamp;
                    ring_handle[ring_head] = fhandle;
                end
                owe_beat(make_beat('0, '0, 1'b0, ok, 1'b1));
            end
            REQ_COLLECT:
            begin
                // oldest to newest, even when the head sits past a shrunken depth
                idx = (ring_head + 1) % span;
                for (i = 0; i < span && !stop; i++)
                begin
                    s   = idx;
                    idx = (idx + 1) % span;
                    if (ring_full[s] && ring_stamp[s] >= ws)
                    begin
                        if (ring_stamp[s] > we)
                            stop = 1'b1;
                        else
                        begin
                            // hold each hit back one step so the final one gets last
                            if (have_hit)
                                owe_beat(hit);
                            hit      = make_beat(ring_handle[s], ring_stamp[s], 1'b1, 1'b0, 1'b0);
                            have_hit = 1'b1;
                        end
                    end
                end
                if (have_hit)
                begin
                    hit.last = 1'b1;
                    owe_beat(hit);
                end
                else
                    owe_beat(make_beat('0, '0, 1'b0, 1'b0, 1'b1));
            end
            REQ_CLEAR:
            begin
                empty_ring_shadow();
                owe_beat(make_beat('0, '0, 1'b0, 1'b0, 1'b1));
            end
            default:
                owe_beat(make_beat('0, '0, 1'b0, 1'b0, 1'b1));
        endcase
    endtask

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    // every result beat is matched against the oldest owed beat
    always @(posedge clk)
    begin : result_check
        ring_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_beats.size() == 0)
            begin
                $error("result beat with nothing owed: handle %h stamp %h", out_handle,
                       out_stamp);
                err_count++;
            end
            else
            begin
                want = due_beats.pop_front();
                check_field("out_handle", 64'(want.handle), 64'(out_handle));
                check_field("out_stamp", 64'(want.stamp), 64'(out_stamp));
                check_field("found", 64'(want.found), 64'(found));
                check_field("accepted", 64'(want.accepted), 64'(accepted));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    // watchdog: any beat or register access counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // drivers, all entered and left on a falling edge
    // ---------------------------------------------------------------------

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        v[47:32] = 16'($urandom);
        v[31:0]  = $urandom;
        return v;
    endfunction

    // one request beat, with random gaps ahead of it; valid drops only during those gaps
    task automatic send_request(input logic [1:0] req, input logic [47:0] now,
                                input logic [47:0] fstamp, input logic [31:0] fhandle,
                                input logic [47:0] ws, input logic [47:0] we);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type     = req;
        arrival_time = now;
        frame_stamp  = fstamp;
        frame_handle = fhandle;
        window_start = ws;
        window_end   = we;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_ring_beats(req, now, fstamp, fhandle, ws, we);
        @(negedge clk);
    endtask

    // hold the sender off until every owed beat has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic settle_for_config();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input int unsigned idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 4'(8 * idx);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_MIN_PERIOD)
            gap_ticks = value[47:0];
        else if (idx == REG_DEPTH)
            depth_setting = value[6:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_clear();
        send_request(REQ_CLEAR, rand48(), rand48(), $urandom, rand48(), rand48());
    endtask

    task automatic collect_all();
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, '0, TIME_MAX);
    endtask

    // well-formed arrivals: each one just clears the rate limit, stamps rising
    task automatic fill_ring(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
        begin
            stamp_cursor = stamp_cursor + $urandom_range(1, 30);
            send_request(REQ_ARRIVAL, last_take_time + gap_ticks + $urandom_range(0, 3),
                         stamp_cursor, $urandom, rand48(), rand48());
        end
    endtask

    // mostly rising stamps, now and then one from anywhere in the range
    function automatic logic [47:0] next_stamp();
        if ($urandom_range(0, 9) == 0)
            return rand48();
        stamp_cursor = stamp_cursor + $urandom_range(0, 40);
        return stamp_cursor;
    endfunction

    // a stamp from the ring when a random probe finds a stored one, else a random one
    function automatic logic [47:0] stored_stamp();
        int unsigned k;
        int unsigned s;
        for (k = 0; k < 8; k++)
        begin
            s = $urandom_range(0, ring_span() - 1);
            if (ring_full[s])
                return ring_stamp[s];
        end
        return rand48();
    endfunction

    task automatic pick_window(output logic [47:0] ws, output logic [47:0] we);
        logic [47:0] a;
        logic [47:0] b;
        logic [47:0] t;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            ws = '0;
            we = TIME_MAX;
        end
        else if (r < 25)
        begin
            ws = rand48();
            we = rand48();
        end
        else
        begin
            a = stored_stamp();
            b = stored_stamp();
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            ws = a - $urandom_range(0, 2);
            we = b + $urandom_range(0, 2);
            // an inverted window now and then
            if (r < 35)
            begin
                t  = ws;
                ws = we;
                we = t;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // rate limit boundaries, window edges, clear and the unused code
    task automatic test_directed_edges();
        // empty ring and the code the block ignores
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, '0, TIME_MAX);
        send_request(REQ_UNUSED, rand48(), rand48(), $urandom, rand48(), rand48());
        // reset period: too soon at zero, exactly on the period, one tick short
        send_request(REQ_ARRIVAL, '0, '0, '0, rand48(), rand48());
        send_request(REQ_ARRIVAL, 48'd333333333, '0, '0, rand48(), rand48());
        send_request(REQ_ARRIVAL, 48'd666666665, rand48(), $urandom, rand48(), rand48());
        // clock running backwards
        send_request(REQ_ARRIVAL, 48'd100, rand48(), $urandom, rand48(), rand48());
        send_request(REQ_ARRIVAL, 48'd666666666, 48'd1000, 32'hA5A5_5A5A, rand48(), rand48());
        send_request(REQ_ARRIVAL, TIME_MAX, TIME_MAX, HANDLE_MAX, rand48(), rand48());
        send_request(REQ_ARRIVAL, TIME_MAX, rand48(), $urandom, rand48(), rand48());
        // ring holds stamps 0, 1000 and the top stamp
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, '0, TIME_MAX);
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, 48'd1000, 48'd1000);
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, '0, '0);
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, 48'd5, '0);
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, TIME_MAX, TIME_MAX);
        // scan stops on the first stamp past the window, so no match is emitted
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, 48'd1, 48'd999);
        send_clear();
        send_request(REQ_COLLECT, rand48(), rand48(), $urandom, '0, TIME_MAX);
        // clear rewinds the limiter
        send_request(REQ_ARRIVAL, TIME_MAX, rand48(), $urandom, rand48(), rand48());

        // widest period: only the top of the clock gets through
        settle_for_config();
        write_reg(REG_MIN_PERIOD, {16'd0, TIME_MAX});
        send_clear();
        send_request(REQ_ARRIVAL, TIME_MAX - 1, rand48(), $urandom, rand48(), rand48());
        send_request(REQ_ARRIVAL, TIME_MAX, rand48(), $urandom, rand48(), rand48());

        // no limit at all: repeated times are both taken
        settle_for_config();
        write_reg(REG_MIN_PERIOD, 64'd0);
        send_clear();
        send_request(REQ_ARRIVAL, '0, 48'd7, 32'd1, rand48(), rand48());
        send_request(REQ_ARRIVAL, '0, 48'd7, 32'd2, rand48(), rand48());
        collect_all();
        send_clear();
    endtask

    // wrap-around at the smallest and largest depths, clamped depths, and a
    // depth change with no clear, which leaves the head past the new end
    task automatic test_ring_depths();
        settle_for_config();
        write_reg(REG_MIN_PERIOD, 64'd10);
        write_reg(REG_DEPTH, 64'd10);
        send_clear();
        fill_ring(14);
        collect_all();

        settle_for_config();
        write_reg(REG_DEPTH, 64'(TB_DEPTH));
        send_clear();
        fill_ring(66);
        collect_all();

        settle_for_config();
        write_reg(REG_DEPTH, 64'd5);
        send_clear();
        fill_ring(12);
        collect_all();

        settle_for_config();
        write_reg(REG_DEPTH, 64'(DIU_MAX));
        send_clear();
        fill_ring(30);
        collect_all();

        settle_for_config();
        write_reg(REG_DEPTH, 64'd10);
        collect_all();
        fill_ring(3);
        collect_all();

        settle_for_config();
        write_reg(REG_DEPTH, 64'(TB_DEPTH));
        send_clear();
    endtask

    // mostly well-formed traffic with random content, plus noise and odd timing
    task automatic test_random_traffic(input int unsigned count, input logic [47:0] gap,
                                       input logic [6:0] depth);
        int unsigned k;
        int unsigned r;
        int unsigned t;
        logic [47:0] now;
        logic [47:0] ws;
        logic [47:0] we;
        settle_for_config();
        write_reg(REG_MIN_PERIOD, {16'd0, gap});
        write_reg(REG_DEPTH, {57'd0, depth});
        send_clear();
        for (k = 0; k < count; k++)
        begin
            // now and then the sender holds off until the block has drained
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 58)
            begin
                t = $urandom_range(0, 99);
                if (t < 70)
                    now = last_take_time + gap_ticks + $urandom_range(0, 50);
                else if (t < 82)
                    now = (gap_ticks != 0) ? last_take_time + (rand48() % gap_ticks)
                                           : last_take_time;
                else if (t < 90)
                    now = last_take_time - 1 - $urandom_range(0, 20);
                else
                    now = rand48();
                send_request(REQ_ARRIVAL, now, next_stamp(), $urandom, rand48(), rand48());
            end
            else if (r < 85)
            begin
                pick_window(ws, we);
                send_request(REQ_COLLECT, rand48(), rand48(), $urandom, ws, we);
            end
            else if (r < 91)
                send_clear();
            else if (r < 95)
                send_request(REQ_UNUSED, rand48(), rand48(), $urandom, rand48(), rand48());
            else
                send_request(2'($urandom_range(0, 3)), rand48(), rand48(), $urandom,
                             rand48(), rand48());
        end
    endtask

    initial
    begin
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        req_type       = REQ_ARRIVAL;
        arrival_time   = '0;
        frame_stamp    = '0;
        frame_handle   = '0;
        window_start   = '0;
        window_end     = '0;
        err_count      = 0;
        stamp_cursor   = '0;
        send_idle_pct  = 18;
        recv_stall_pct = 72;

        // shadow ring starts from the reset register values
        gap_ticks     = MIN_PERIOD_RST[47:0];
        depth_setting = 7'(DIU_RST);
        empty_ring_shadow();

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_ring_depths();
        test_random_traffic(70, 48'd1000, 7'd37);

        send_idle_pct  = 72;
        recv_stall_pct = 18;
        test_random_traffic(70, 48'd0, 7'd10);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(70, 48'd10, 7'd64);

        // let stray beats show up before the verdict
        wait_drained();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
